@@ hw/rtl/mml_pkg.sv @@
// ----------------------------------------------------------------------------
// mml_pkg
// Types and constants shared by the note sequence parser modules.
// ----------------------------------------------------------------------------
package mml_pkg;

  localparam int unsigned DUR_W  = 19;
  localparam int unsigned FREQ_W = 17;
  localparam int unsigned MIDI_W = 7;

  // Duration numerator base: 240000 ms per whole note at 1 BPM.
  localparam int unsigned WHOLE_MS = 240000;

  typedef struct packed {
    logic       cmd;
    logic [7:0] char_code;
  } mml_in_t;

  typedef struct packed {
    logic              is_rest;
    logic [MIDI_W-1:0] midi_note;
    logic [FREQ_W-1:0] freq_sixteenth_hz;
    logic [DUR_W-1:0]  duration_ms;
  } mml_out_t;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_TNUM     = 4'd1,
    PH_ONUM     = 4'd2,
    PH_LNUM     = 4'd3,
    PH_NOTE_ACC = 4'd4,
    PH_NOTE_LEN = 4'd5,
    PH_NOTE_DOT = 4'd6,
    PH_REST_LEN = 4'd7,
    PH_REST_DOT = 4'd8
  } mml_phase_t;

  typedef enum logic [1:0] {
    DV_IDLE = 2'd0,
    DV_MUL  = 2'd1,
    DV_DIV  = 2'd2,
    DV_OUT  = 2'd3
  } mml_dv_state_t;

  function automatic logic [FREQ_W-1:0] oct8_freq(input logic [3:0] semi);
    logic [FREQ_W-1:0] f;
    begin
      unique case (semi)
        4'd0:  f = 17'd66976;
        4'd1:  f = 17'd70959;
        4'd2:  f = 17'd75178;
        4'd3:  f = 17'd79649;
        4'd4:  f = 17'd84385;
        4'd5:  f = 17'd89402;
        4'd6:  f = 17'd94719;
        4'd7:  f = 17'd100351;
        4'd8:  f = 17'd106318;
        4'd9:  f = 17'd112640;
        4'd10: f = 17'd119338;
        4'd11: f = 17'd126434;
        default: f = 17'd0;
      endcase
      return f;
    end
  endfunction

  function automatic logic [3:0] letter_semi(input logic [2:0] idx);
    logic [3:0] s;
    begin
      unique case (idx)
        3'd0: s = 4'd9;
        3'd1: s = 4'd11;
        3'd2: s = 4'd0;
        3'd3: s = 4'd2;
        3'd4: s = 4'd4;
        3'd5: s = 4'd5;
        3'd6: s = 4'd7;
        default: s = 4'd0;
      endcase
      return s;
    end
  endfunction

endpackage

@@ hw/rtl/mml_front.sv @@
// ----------------------------------------------------------------------------
// mml_front
// Character parser: tracks tempo, octave, length and the open note or rest,
// and hands closed events to the queue.
// ----------------------------------------------------------------------------
module mml_front #(
  parameter int unsigned MAX_DOTS    = 7,
  parameter int unsigned NUMBER_BITS = 16,
  parameter int unsigned DOT_W       = 4,
  parameter int unsigned JOB_W       = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mml_pkg::mml_in_t     in_data,
  output logic                 job_valid,
  input  logic                 job_ready,
  output logic [JOB_W-1:0]     job_data
);
  import mml_pkg::*;

  localparam logic [NUMBER_BITS-1:0] NUM_MAX = '1;

  mml_phase_t             phase_r, phase_nxt;
  logic [NUMBER_BITS-1:0] tempo_r, tempo_nxt;
  logic [3:0]             oct_r, oct_nxt;
  logic [NUMBER_BITS-1:0] dlen_r, dlen_nxt;
  logic [NUMBER_BITS-1:0] acc_r, acc_nxt;
  logic [3:0]             semi_r, semi_nxt;
  logic [DOT_W-1:0]       dots_r, dots_nxt;

  logic [7:0]             c, u;
  logic                   is_digit, num_ph, dot_ph, rest;
  logic [NUMBER_BITS+3:0] dig_sum;
  logic [NUMBER_BITS-1:0] len;
  logic                   emit;

  assign c        = in_data.char_code;
  assign u        = (c >= 8'h61 && c <= 8'h7a) ? c - 8'd32 : c;
  assign is_digit = c >= 8'h30 && c <= 8'h39;
  assign num_ph   = phase_r == PH_TNUM || phase_r == PH_ONUM || phase_r == PH_LNUM ||
                    phase_r == PH_NOTE_ACC || phase_r == PH_NOTE_LEN ||
                    phase_r == PH_REST_LEN;
  assign dot_ph   = phase_r == PH_NOTE_ACC || phase_r == PH_NOTE_LEN ||
                    phase_r == PH_NOTE_DOT || phase_r == PH_REST_LEN ||
                    phase_r == PH_REST_DOT;
  assign rest     = phase_r == PH_REST_LEN || phase_r == PH_REST_DOT;
  assign dig_sum  = {4'd0, acc_r} * (NUMBER_BITS+4)'(10) + (NUMBER_BITS+4)'(c - 8'h30);
  assign len      = (acc_r != '0) ? acc_r : dlen_r;

  // A job is needed when the current beat closes an open note or rest.
  logic closes;
  always_comb begin
    closes = 1'b0;
    if (in_data.cmd) closes = 1'b1;
    else if (num_ph && is_digit) closes = 1'b0;
    else if (phase_r == PH_NOTE_ACC && (c == 8'h23 || c == 8'h2b || c == 8'h2d))
      closes = 1'b0;
    else if (dot_ph && c == 8'h2e) closes = 1'b0;
    else closes = 1'b1;
  end
  assign emit     = closes && dot_ph;
  assign in_ready = !emit || job_ready;
  assign job_valid = in_valid && emit;
  assign job_data  = JOB_W'({rest, oct_r, semi_r, dots_r, tempo_r, len});

  always_comb begin
    phase_nxt = phase_r;
    tempo_nxt = tempo_r;
    oct_nxt   = oct_r;
    dlen_nxt  = dlen_r;
    acc_nxt   = acc_r;
    semi_nxt  = semi_r;
    dots_nxt  = dots_r;
    if (!closes) begin
      if (num_ph && is_digit) begin
        acc_nxt = (dig_sum > {4'd0, NUM_MAX}) ? NUM_MAX : dig_sum[NUMBER_BITS-1:0];
        if (phase_r == PH_NOTE_ACC) phase_nxt = PH_NOTE_LEN;
      end else if (phase_r == PH_NOTE_ACC && c != 8'h2e) begin
        semi_nxt  = (c == 8'h2d) ? ((semi_r == 4'd0) ? 4'd11 : semi_r - 4'd1)
                                 : ((semi_r == 4'd11) ? 4'd0 : semi_r + 4'd1);
        phase_nxt = PH_NOTE_LEN;
      end else begin
        if (dots_r < DOT_W'(MAX_DOTS)) dots_nxt = dots_r + 1'b1;
        phase_nxt = rest ? PH_REST_DOT : PH_NOTE_DOT;
      end
    end else begin
      // close the pending command
      unique case (phase_r)
        PH_TNUM: if (acc_r != '0) tempo_nxt = acc_r;
        PH_ONUM: if (acc_r <= NUMBER_BITS'(8)) oct_nxt = acc_r[3:0];
        PH_LNUM: if (acc_r != '0) dlen_nxt = acc_r;
        default: ;
      endcase
      phase_nxt = PH_IDLE;
      acc_nxt   = '0;
      dots_nxt  = '0;
      if (in_data.cmd) begin
        tempo_nxt = NUMBER_BITS'(120);
        oct_nxt   = 4'd4;
        dlen_nxt  = NUMBER_BITS'(4);
        semi_nxt  = 4'd0;
      end else begin
        priority if (u == 8'h54) phase_nxt = PH_TNUM;
        else if (u == 8'h4f) phase_nxt = PH_ONUM;
        else if (u == 8'h4c) phase_nxt = PH_LNUM;
        else if (u == 8'h3e) begin
          if (oct_nxt < 4'd8) oct_nxt = oct_nxt + 4'd1;
        end else if (u == 8'h3c) begin
          if (oct_nxt > 4'd0) oct_nxt = oct_nxt - 4'd1;
        end else if (u == 8'h50 || u == 8'h52) phase_nxt = PH_REST_LEN;
        else if (u >= 8'h41 && u <= 8'h47) begin
          semi_nxt  = letter_semi(3'(u - 8'h41));
          phase_nxt = PH_NOTE_ACC;
        end else begin
          // whitespace and unknown characters
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      tempo_r <= NUMBER_BITS'(120);
      oct_r   <= 4'd4;
      dlen_r  <= NUMBER_BITS'(4);
      acc_r   <= '0;
      semi_r  <= 4'd0;
      dots_r  <= '0;
    end else if (in_valid && in_ready) begin
      phase_r <= phase_nxt;
      tempo_r <= tempo_nxt;
      oct_r   <= oct_nxt;
      dlen_r  <= dlen_nxt;
      acc_r   <= acc_nxt;
      semi_r  <= semi_nxt;
      dots_r  <= dots_nxt;
    end
  end
endmodule

@@ hw/rtl/mml_queue.sv @@
// ----------------------------------------------------------------------------
// mml_queue
// Two-entry job queue between parser and duration unit.
// ----------------------------------------------------------------------------
module mml_queue #(
  parameter int unsigned W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_valid,
  output logic         wr_ready,
  input  logic [W-1:0] wr_data,
  output logic         rd_valid,
  input  logic         rd_ready,
  output logic [W-1:0] rd_data
);
  logic [W-1:0] mem_r [2];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r;
  logic         wr, rd;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data  = mem_r[rp_r];
  assign wr       = wr_valid && wr_ready;
  assign rd       = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= !wp_r;
      if (rd) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end
endmodule

@@ hw/rtl/mml_back.sv @@
// ----------------------------------------------------------------------------
// mml_back
// Event unit: tempo*length product, restoring divide for the duration,
// frequency shift, output register.
// ----------------------------------------------------------------------------
module mml_back #(
  parameter int unsigned NUMBER_BITS = 16,
  parameter int unsigned DOT_W       = 4,
  parameter int unsigned JOB_W       = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_valid,
  output logic               job_ready,
  input  logic [JOB_W-1:0]   job_data,
  output logic               out_valid,
  input  logic               out_ready,
  output mml_pkg::mml_out_t  out_data
);
  import mml_pkg::*;

  localparam int unsigned PW  = 2 * NUMBER_BITS;     // product width
  localparam int unsigned NW  = 20 + 16 + 2;         // numerator width
  localparam int unsigned DW  = PW + 16 + 1;         // denominator width
  localparam int unsigned QW  = DUR_W + 1;           // quotient bits kept
  localparam int unsigned CW  = $clog2(QW + 1);

  logic                   j_rest;
  logic [3:0]             j_oct, j_semi;
  logic [DOT_W-1:0]       j_dots;
  logic [NUMBER_BITS-1:0] j_tempo, j_len;
  assign {j_rest, j_oct, j_semi, j_dots, j_tempo, j_len} =
    job_data[1+4+4+DOT_W+2*NUMBER_BITS-1:0];

  mml_dv_state_t st_r, st_nxt;
  logic [PW-1:0]  prod_r;
  logic [DOT_W-1:0] dots_r;
  logic [DW-1:0]  den_r;
  logic [DW+NW-1:0] rem_r;
  logic [QW-1:0]  quo_r;
  logic [CW-1:0]  cnt_r;
  logic           rest_r;
  logic [MIDI_W-1:0] midi_r;
  logic [FREQ_W-1:0] freq_r;
  mml_out_t       obuf_r;
  logic           ovalid_r;

  logic [DW+NW-1:0] trial;
  logic [NW-1:0]    num2;
  logic             big;

  // 2*num + den over 2*den; quotient fits in QW bits so shift over QW steps.
  assign num2 = ((NW'(2 * WHOLE_MS) << dots_r) << 1) - NW'(2 * WHOLE_MS);
  assign big  = prod_r[PW-1:40 < PW ? 40 : PW-1] != '0 && PW > 40;
  assign trial = (DW+NW)'({den_r, 1'b0}) << (cnt_r - 1'b1);

  assign job_ready = st_r == DV_IDLE;
  assign out_valid = ovalid_r;
  assign out_data  = obuf_r;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      DV_IDLE: if (job_valid) st_nxt = DV_MUL;
      DV_MUL:  st_nxt = DV_DIV;
      DV_DIV:  if (cnt_r == '0) st_nxt = DV_OUT;
      DV_OUT:  if (!ovalid_r || out_ready) st_nxt = DV_IDLE;
      default: st_nxt = DV_IDLE;
    endcase
  end

  logic [3:0]        oc;
  logic [3:0]        sh;
  logic [FREQ_W:0]   fr;
  assign oc = (j_oct > 4'd8) ? 4'd8 : j_oct;
  assign sh = 4'd8 - oc;
  assign fr = ({1'b0, oct8_freq(j_semi)} +
               ((sh == 4'd0) ? '0 : ((FREQ_W+1)'(1) << (sh - 4'd1)))) >> sh;

  always_ff @(posedge clk) begin
    unique case (st_r)
      DV_IDLE: if (job_valid) begin
        prod_r <= PW'(j_tempo) * PW'(j_len);
        dots_r <= j_dots;
        rest_r <= j_rest;
        midi_r <= j_rest ? '0 : MIDI_W'((oc + 4'd1) * 4'd12 + {3'd0, j_semi});
        freq_r <= j_rest ? '0 : fr[FREQ_W-1:0];
      end
      DV_MUL: begin
        den_r <= DW'({prod_r, 1'b0}) << dots_r;
        rem_r <= (prod_r == '0 || big) ? '0 :
                 (DW+NW)'(num2) + ((DW+NW)'(prod_r) << dots_r);
        quo_r <= '0;
        cnt_r <= CW'(QW);
      end
      DV_DIV: if (cnt_r != '0) begin
        if (rem_r >= trial >> 1) begin
          rem_r <= rem_r - (trial >> 1);
          quo_r <= {quo_r[QW-2:0], 1'b1};
        end else begin
          quo_r <= {quo_r[QW-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
      end
      default: ;
    endcase
  end

  logic load;
  assign load = st_r == DV_OUT && (!ovalid_r || out_ready) && quo_r != '0;

  always_ff @(posedge clk) begin
    if (load) begin
      obuf_r.is_rest           <= rest_r;
      obuf_r.midi_note         <= midi_r;
      obuf_r.freq_sixteenth_hz <= freq_r;
      obuf_r.duration_ms       <= quo_r[DUR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= DV_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (load) ovalid_r <= 1'b1;
      else if (out_ready) ovalid_r <= 1'b0;
    end
  end
endmodule

@@ hw/rtl/mml_note_sequence_parser.sv @@
// ----------------------------------------------------------------------------
// mml_note_sequence_parser
// MML character stream in, tone and rest events out.
// ----------------------------------------------------------------------------
//  channel | ports                        | payload
//  input   | in_valid / in_ready          | cmd, char_code
//  output  | out_valid / out_ready        | is_rest, midi_note, freq, duration
//
// A closed note or rest is queued; the event unit takes it through a
// multiply, a 20-step restoring divide and an output load. The parser
// stalls only when the two-entry queue is full.
// Reset is synchronous and clears state to T120 O4 L4.
module mml_note_sequence_parser #(
  parameter int unsigned MAX_DOTS    = 7,
  parameter int unsigned NUMBER_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  mml_pkg::mml_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output mml_pkg::mml_out_t out_data
);
  import mml_pkg::*;

  localparam int unsigned DOT_W = $clog2(MAX_DOTS + 1);
  localparam int unsigned JOB_W = 1 + 4 + 4 + DOT_W + 2 * NUMBER_BITS;

  logic             f_valid, f_ready, b_valid, b_ready;
  logic [JOB_W-1:0] f_data, b_data;

  mml_front #(.MAX_DOTS(MAX_DOTS), .NUMBER_BITS(NUMBER_BITS), .DOT_W(DOT_W),
              .JOB_W(JOB_W)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .job_valid(f_valid), .job_ready(f_ready), .job_data(f_data));

  mml_queue #(.W(JOB_W)) u_queue (
    .clk, .rst_n, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
    .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_data));

  mml_back #(.NUMBER_BITS(NUMBER_BITS), .DOT_W(DOT_W), .JOB_W(JOB_W)) u_back (
    .clk, .rst_n, .job_valid(b_valid), .job_ready(b_ready), .job_data(b_data),
    .out_valid, .out_ready, .out_data);

  a_dur_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.duration_ms != '0) else $error("zero duration");
  a_rest_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_rest |-> out_data.midi_note == '0 &&
    out_data.freq_sixteenth_hz == '0) else $error("rest with pitch");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output dropped");
endmodule

@@ verif/mml_note_sequence_parser_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mml_note_sequence_parser_tb
// Self-checking bench: directed table then random MML strings, events checked
// in order against a behavioral parser, with random idling and a long hold-off.
// ----------------------------------------------------------------------------
module mml_note_sequence_parser_tb;
  import mml_pkg::*;

  localparam int unsigned MAX_DOTS    = 7;
  localparam int unsigned NUMBER_BITS = 16;
  localparam int unsigned STALL_LIMIT = 20000;
  localparam logic CMD_CHAR = 1'b0;
  localparam logic CMD_END  = 1'b1;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  mml_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  mml_out_t out_data;

  mml_note_sequence_parser #(
    .MAX_DOTS   (MAX_DOTS),
    .NUMBER_BITS(NUMBER_BITS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // parser copy
  mml_phase_t  ph;
  logic [15:0] tempo;
  logic [3:0]  octave;
  logic [15:0] def_len;
  logic [15:0] num;
  logic [3:0]  semi;
  logic [3:0]  dots;

  mml_out_t event_q[$];
  int       n_err;
  int       send_idle_pct;
  int       recv_stall_pct;
  bit       hold_off;
  int       idle_cycles;

  const logic [16:0] FREQ8 [12] = '{17'd66976, 17'd70959, 17'd75178, 17'd79649,
    17'd84385, 17'd89402, 17'd94719, 17'd100351, 17'd106318, 17'd112640,
    17'd119338, 17'd126434};
  const logic [3:0] LETTER_SEMI [7] = '{4'd9, 4'd11, 4'd0, 4'd2, 4'd4, 4'd5, 4'd7};

  task automatic clear_parser();
    ph = PH_IDLE; tempo = 16'd120; octave = 4'd4; def_len = 16'd4;
    num = '0; semi = '0; dots = '0;
  endtask

  // closes whatever is open; pushes an event when a nonzero duration results
  task automatic close_open();
    logic [63:0] len, prod, den, numer, dur;
    logic [3:0]  oct, sh;
    mml_out_t    ev;
    if (ph == PH_TNUM) begin
      if (num != 0) tempo = num;
    end else if (ph == PH_ONUM) begin
      if (num <= 8) octave = num[3:0];
    end else if (ph == PH_LNUM) begin
      if (num != 0) def_len = num;
    end else if (ph >= PH_NOTE_ACC && ph <= PH_REST_DOT) begin
      len = (num != 0) ? 64'(num) : 64'(def_len);
      prod = 64'(tempo) * len;
      den = prod << dots;
      numer = 64'(WHOLE_MS) * ((64'd2 << dots) - 1);
      dur = (2 * numer + den) / (2 * den);
      if (dur != 0) begin
        ev = '0;
        ev.is_rest = (ph >= PH_REST_LEN);
        if (!ev.is_rest) begin
          oct = (octave > 8) ? 4'd8 : octave;
          sh = 4'd8 - oct;
          ev.midi_note = 7'((oct + 1) * 12 + semi);
          ev.freq_sixteenth_hz = (sh == 0) ? FREQ8[semi] :
            17'((18'(FREQ8[semi]) + (18'd1 << (sh - 1))) >> sh);
        end
        ev.duration_ms = dur[18:0];
        event_q.push_back(ev);
      end
    end
    ph = PH_IDLE; num = '0; dots = '0;
  endtask

  task automatic parse_beat(input mml_in_t b);
    logic [7:0]  c, u;
    logic [31:0] v;
    bit          dig;
    c = b.char_code;
    dig = (c >= "0" && c <= "9");
    if (b.cmd == CMD_END) begin
      close_open();
      clear_parser();
      return;
    end
    if (dig && (ph inside {PH_TNUM, PH_ONUM, PH_LNUM, PH_NOTE_ACC, PH_NOTE_LEN,
                           PH_REST_LEN})) begin
      v = num * 10 + (c - "0");
      num = (v > 32'hFFFF) ? 16'hFFFF : v[15:0];
      if (ph == PH_NOTE_ACC) ph = PH_NOTE_LEN;
      return;
    end
    if (ph == PH_NOTE_ACC && (c == "#" || c == "+")) begin
      semi = (semi == 4'd11) ? 4'd0 : semi + 4'd1;
      ph = PH_NOTE_LEN;
      return;
    end
    if (ph == PH_NOTE_ACC && c == "-") begin
      semi = (semi == 4'd0) ? 4'd11 : semi - 4'd1;
      ph = PH_NOTE_LEN;
      return;
    end
    if (c == "." && ph >= PH_NOTE_ACC && ph <= PH_REST_DOT) begin
      if (dots < MAX_DOTS) dots++;
      ph = (ph >= PH_REST_LEN) ? PH_REST_DOT : PH_NOTE_DOT;
      return;
    end
    close_open();
    u = (c >= "a" && c <= "z") ? c - 8'd32 : c;
    if (u == "T") ph = PH_TNUM;
    else if (u == "O") ph = PH_ONUM;
    else if (u == "L") ph = PH_LNUM;
    else if (u == ">") begin
      if (octave < 8) octave++;
    end else if (u == "<") begin
      if (octave > 0) octave--;
    end else if (u == "P" || u == "R") ph = PH_REST_LEN;
    else if (u >= "A" && u <= "G") begin
      semi = LETTER_SEMI[u - "A"];
      ph = PH_NOTE_ACC;
    end
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    n_err++;
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog: cycles without any accepted beat or delivered event
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result checker
  always @(posedge clk) begin
    mml_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (event_q.size() == 0) begin
        report("unexpected event", out_data.duration_ms, 0);
      end else begin
        want = event_q.pop_front();
        if (out_data.is_rest !== want.is_rest)
          report("is_rest", out_data.is_rest, want.is_rest);
        if (out_data.midi_note !== want.midi_note)
          report("midi_note", out_data.midi_note, want.midi_note);
        if (out_data.freq_sixteenth_hz !== want.freq_sixteenth_hz)
          report("freq", out_data.freq_sixteenth_hz, want.freq_sixteenth_hz);
        if (out_data.duration_ms !== want.duration_ms)
          report("duration", out_data.duration_ms, want.duration_ms);
      end
    end
  end

  // receiver
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) out_ready <= 1'b0;
      else out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_beat(input logic c, input logic [7:0] ch);
    mml_in_t b;
    b.cmd = c;
    b.char_code = ch;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    parse_beat(b);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) send_beat(CMD_CHAR, s[i]);
  endtask

  task automatic send_number(input int maxv);
    int v;
    v = $urandom_range(maxv);
    send_str($sformatf("%0d", v));
  endtask

  // random piece of MML: mostly well formed, some noise
  task automatic send_random_token();
    int k;
    k = $urandom_range(99);
    if (k < 40) begin
      send_beat(CMD_CHAR, 8'("A" + $urandom_range(6) + ($urandom_range(1) ? 32 : 0)));
      case ($urandom_range(3))
        0: send_str("#");
        1: send_str("+");
        2: send_str("-");
        default: ;
      endcase
      if ($urandom_range(1)) send_number($urandom_range(9) == 0 ? 99999 : 64);
      repeat ($urandom_range(9) < 7 ? 0 : $urandom_range(9)) send_str(".");
    end else if (k < 55) begin
      send_str($urandom_range(1) ? "r" : "P");
      if ($urandom_range(1)) send_number(32);
      repeat ($urandom_range(3) == 0 ? $urandom_range(9) : 0) send_str(".");
    end else if (k < 65) begin
      send_str($urandom_range(1) ? "T" : "t");
      send_number($urandom_range(9) == 0 ? 99999 : 300);
    end else if (k < 73) begin
      send_str($urandom_range(1) ? "O" : "o");
      send_number(10);
    end else if (k < 80) begin
      send_str($urandom_range(1) ? "L" : "l");
      send_number($urandom_range(9) == 0 ? 99999 : 64);
    end else if (k < 86) begin
      send_str($urandom_range(1) ? "<" : ">");
    end else if (k < 90) begin
      send_str(" ");
    end else if (k < 93) begin
      send_beat(CMD_END, 8'($urandom));
    end else begin
      send_beat(CMD_CHAR, 8'($urandom));
    end
  endtask

  task automatic drain();
    while (event_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    @(negedge clk);
  endtask

  typedef struct {
    logic        cmd;
    string       text;
    bit          typed;
    logic        want_rest;
    logic [6:0]  want_midi;
    logic [16:0] want_freq;
    logic [18:0] want_dur;
  } row_t;

  row_t rows[$];

  initial begin
    row_t r;
    int   p;
    in_valid = 1'b0;
    in_data = '0;
    rst_n = 1'b0;
    hold_off = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    n_err = 0;
    idle_cycles = 0;
    clear_parser();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // table: text, then an end beat (typed) or a cmd beat; typed where obvious
    rows = '{
      '{CMD_CHAR, "a", 1, 0, 7'd69, 17'd7040, 19'd500},
      '{CMD_CHAR, "P1", 1, 1, 7'd0, 17'd0, 19'd2000},
      '{CMD_CHAR, "o8b", 1, 0, 7'd119, 17'd126434, 19'd500},
      '{CMD_CHAR, "o0c", 1, 0, 7'd12, 17'd262, 19'd500},
      '{CMD_CHAR, "T65535L65535R", 0, 0, 0, 0, 0},
      '{CMD_CHAR, "T1L1c.......", 1, 0, 7'd60, 17'd4186, 19'd478125},
      '{CMD_CHAR, "c+d-e#F", 0, 0, 0, 0, 0},
      '{CMD_CHAR, "O9>>>>>>b<<<<<<<<<<c", 0, 0, 0, 0, 0},
      '{CMD_CHAR, "T0L0r0g999999.........", 0, 0, 0, 0, 0},
      '{CMD_CHAR, "t300l64 a . b8.x?r16z", 0, 0, 0, 0, 0},
      '{CMD_CHAR, "c-", 1, 0, 7'd71, 17'd7902, 19'd500},
      '{CMD_CHAR, "b#", 1, 0, 7'd60, 17'd4186, 19'd500},
      '{CMD_CHAR, "l8 d..2e3#", 0, 0, 0, 0, 0},
      '{CMD_END,  "", 0, 0, 0, 0, 0}
    };
    foreach (rows[i]) begin
      r = rows[i];
      if (r.typed) begin
        // start from defaults with nothing in flight, then check the predictor
        send_beat(CMD_END, 8'h00);
        drain();
        send_str(r.text);
        p = event_q.size();
        send_beat(CMD_END, 8'hFF);
        if (event_q.size() != p + 1) report("table event count", event_q.size(), p + 1);
        else if (event_q[p] !== {r.want_rest, r.want_midi, r.want_freq, r.want_dur})
          report("table row", i, 0);
      end else begin
        send_str(r.text);
        send_beat(r.cmd, 8'h41);
      end
    end
    drain();

    // a long receiver hold-off while beats keep coming
    hold_off = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      repeat (20) send_str("c16");
    join
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      repeat (150) send_random_token();
    end
    send_beat(CMD_END, 8'h00);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain();

    if (n_err == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
